// File: hdl/bcd_clock_field_editor_core_macros.svh
// Assertion macros for the BCD clock field editor.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef BCD_CLOCK_FIELD_EDITOR_CORE_MACROS_SVH
`define BCD_CLOCK_FIELD_EDITOR_CORE_MACROS_SVH

// Condition implies consequence in the same cycle
`define BCFE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle
`define BCFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bcfe_pkg.sv
// Shared types, constants and field tables for the BCD clock field editor.
// No dependencies; imported by bcfe_step and the top level.
package bcfe_pkg;

  localparam int unsigned ValW      = 8;
  localparam int unsigned NumFields = 6;
  localparam int unsigned IdxW      = 3;

  typedef logic [ValW-1:0] val_t;
  typedef logic [IdxW-1:0] field_idx_t;

  // Field positions
  localparam field_idx_t FieldHour  = 3'd0;
  localparam field_idx_t FieldMin   = 3'd1;
  localparam field_idx_t FieldSec   = 3'd2;
  localparam field_idx_t FieldDay   = 3'd3;
  localparam field_idx_t FieldMonth = 3'd4;
  localparam field_idx_t FieldYear  = 3'd5;

  // Button event codes; the remaining code is ignored
  typedef enum logic [1:0] {
    BtnMenu = 2'd0,
    BtnInc  = 2'd1,
    BtnDec  = 2'd2
  } button_e;

  // Control handed to the step unit
  typedef struct packed {
    logic       up;
    field_idx_t field;
  } step_ctl_t;

  // Lowest legal value of a field
  function automatic val_t field_min(field_idx_t idx);
    val_t r;
    unique case (idx) inside
      FieldDay, FieldMonth, FieldYear: r = 8'd1;
      default:                         r = 8'd0;
    endcase
    return r;
  endfunction

  // One past the highest legal value of a field
  function automatic val_t field_lim(field_idx_t idx);
    val_t r;
    unique case (idx)
      FieldHour:  r = 8'd24;
      FieldMin:   r = 8'd60;
      FieldSec:   r = 8'd60;
      FieldDay:   r = 8'd32;
      FieldMonth: r = 8'd13;
      FieldYear:  r = 8'd100;
      default:    r = 8'd24;
    endcase
    return r;
  endfunction

  // Display cursor address of a field
  function automatic val_t field_addr(field_idx_t idx);
    val_t r;
    unique case (idx)
      FieldHour:  r = 8'h80;
      FieldMin:   r = 8'h83;
      FieldSec:   r = 8'h86;
      FieldDay:   r = 8'hC0;
      FieldMonth: r = 8'hC3;
      FieldYear:  r = 8'hC6;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/bcfe_step.sv
// Step unit: BCD to binary, increment or decrement with wrap, back to BCD.
// Depends on bcfe_pkg for field limits and the control struct.
module bcfe_step (
  input  bcfe_pkg::val_t      bcd_i,
  input  bcfe_pkg::step_ctl_t ctl_i,
  output bcfe_pkg::val_t      bcd_o
);
  import bcfe_pkg::*;

  val_t        bin;
  val_t        lo;
  val_t        lim;
  val_t        stepped;
  logic [6:0]  wrapped;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [3:0]  ones;

  // Nibbles taken at their weight, so invalid digits give up to 165
  assign bin = ValW'({4'd0, bcd_i[7:4]} * 8'd10) + {4'd0, bcd_i[3:0]};
  assign lo  = field_min(ctl_i.field);
  assign lim = field_lim(ctl_i.field);

  // Step; decrement at or below the minimum wraps to the maximum
  always_comb begin
    if (ctl_i.up) begin
      stepped = bin + 8'd1;
    end else if (bin <= lo) begin
      stepped = lim - 8'd1;
    end else begin
      stepped = bin - 8'd1;
    end
  end

  // Anything at or past the limit goes to the minimum; result stays below 100
  assign wrapped = (stepped >= lim) ? lo[6:0] : stepped[6:0];

  // Divide by ten through a reciprocal, exact for every 7-bit value (below 128)
  assign prod  = {8'd0, wrapped} * 15'd205;
  assign tens  = prod[14:11];
  assign ones  = 4'(wrapped - 7'({3'd0, tens} * 7'd10));
  assign bcd_o = {tens, ones};

endmodule

// File: hdl/bcd_clock_field_editor_core.sv
// Top level of the BCD clock field editor: input register, edit state and
// result register. Depends on bcfe_pkg, bcfe_step and the assertion macros.
//
// Usage:
//   Slave channel: one item per button event. s_axis_tuser carries the button
//   code, s_axis_tdata the current BCD time, read only when a menu press
//   starts an edit. Master channel: one result item per input item with the
//   edit status, the selected field, its BCD value, the cursor address, the
//   commit flag and the six held fields.
//   Path: an accepted item passes through the input register and then the
//   result register before it appears on the master channel.
//   Throughput: one item per cycle while m_axis_tready is high; the edit
//   state is updated by a single pass of the step unit, so consecutive items
//   chain with no gap. Stall: while m_axis_tready is low a valid result is
//   held; an empty input register still takes one more item, after which
//   s_axis_tready drops. Reset: both registers empty, editing off, field
//   index at hours and all six held fields zero.
`include "bcd_clock_field_editor_core_macros.svh"

module bcd_clock_field_editor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_hour, now_minute, now_second, now_day, now_month, now_year
  input  logic [47:0] s_axis_tdata,
  // button
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // editing, field_selected, shown_value, cursor_address, commit,
  // set_hour, set_minute, set_second, set_day, set_month, set_year, zero pad
  output logic [71:0] m_axis_tdata
);
  import bcfe_pkg::*;

  // Input register
  logic        in_valid_q;
  logic [47:0] in_data_q;
  logic [1:0]  in_user_q;

  // Edit state
  logic       edit_q, edit_d;
  field_idx_t idx_q, idx_d;
  val_t       fields_q [NumFields];
  val_t       fields_d [NumFields];

  // Result register
  logic       out_valid_q;
  logic       out_edit_q;
  field_idx_t out_field_q;
  val_t       out_shown_q;
  val_t       out_cursor_q;
  logic       out_commit_q;
  val_t       out_set_q [NumFields];

  logic       advance;
  logic       commit;
  step_ctl_t  step_ctl;
  val_t       step_bcd;

  // Handshake
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
  end

  // Step the selected field
  assign step_ctl.up    = (button_e'(in_user_q) == BtnInc);
  assign step_ctl.field = idx_q;

  bcfe_step u_step (
    .bcd_i (fields_q[idx_q]),
    .ctl_i (step_ctl),
    .bcd_o (step_bcd)
  );

  // Next edit state for the item in the input register
  always_comb begin
    edit_d = edit_q;
    idx_d  = idx_q;
    commit = 1'b0;
    for (int i = 0; i < NumFields; i++) begin
      fields_d[i] = fields_q[i];
    end
    if (!edit_q) begin
      if (button_e'(in_user_q) == BtnMenu) begin
        for (int i = 0; i < NumFields; i++) begin
          fields_d[i] = in_data_q[i*ValW +: ValW];
        end
        edit_d = 1'b1;
        idx_d  = FieldHour;
      end
    end else begin
      unique case (button_e'(in_user_q)) inside
        BtnInc, BtnDec: begin
          fields_d[idx_q] = step_bcd;
        end
        BtnMenu: begin
          if (idx_q == FieldYear) begin
            idx_d  = FieldHour;
            edit_d = 1'b0;
            commit = 1'b1;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State update when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edit_q <= 1'b0;
      idx_q  <= FieldHour;
      for (int i = 0; i < NumFields; i++) begin
        fields_q[i] <= '0;
      end
    end else if (in_valid_q && advance) begin
      edit_q <= edit_d;
      idx_q  <= idx_d;
      for (int i = 0; i < NumFields; i++) begin
        fields_q[i] <= fields_d[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      out_edit_q   <= edit_d;
      out_field_q  <= edit_d ? idx_d : FieldHour;
      out_shown_q  <= edit_d ? fields_d[idx_d] : '0;
      out_cursor_q <= edit_d ? field_addr(idx_d) : '0;
      out_commit_q <= commit;
      for (int i = 0; i < NumFields; i++) begin
        out_set_q[i] <= fields_d[i];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0,
                          out_set_q[5], out_set_q[4], out_set_q[3],
                          out_set_q[2], out_set_q[1], out_set_q[0],
                          out_commit_q, out_cursor_q, out_shown_q,
                          out_field_q, out_edit_q};

  // Checks
  `BCFE_ASSERT_SAME(a_idx_range, 1'b1, idx_q <= FieldYear, "field index out of range")
  `BCFE_ASSERT_SAME(a_commit_idle, out_valid_q && out_commit_q,
                    !out_edit_q && out_field_q == FieldHour, "commit while editing")
  `BCFE_ASSERT_NEXT(a_year_menu_commits,
                    in_valid_q && advance && edit_q && idx_q == FieldYear &&
                    in_user_q == BtnMenu,
                    !edit_q && out_commit_q && out_valid_q, "menu on year did not commit")
  `BCFE_ASSERT_SAME(a_idle_blank, out_valid_q && !out_edit_q,
                    out_cursor_q == 8'h00 && out_shown_q == 8'h00, "idle result not blank")

endmodule
